>>> hdl/skinned_palette_bounds_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the skinned palette bounds core
// Shorthand for clocked checks that are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SKINNED_PALETTE_BOUNDS_CORE_MACROS_SVH
`define SKINNED_PALETTE_BOUNDS_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/spb_pkg.sv
// ----------------------------------------------------------------------------
// Skinned palette bounds package
// Shared types, codes and arithmetic helpers of the bounds core.
// ----------------------------------------------------------------------------
package spb_pkg;

    // Signed Q16.16 value, a full product and a three-term sum.
    typedef logic signed [31:0] q16_t;
    typedef logic signed [63:0] prod_t;
    typedef logic signed [64:0] sum_t;

    localparam int unsigned NUM_AXES    = 3;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam q16_t SAT_MAX = 32'sh7FFF_FFFF;
    localparam q16_t SAT_MIN = 32'sh8000_0000;

    // Output axis codes; the last code carries no axis.
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_BIND_MIN_X     = 3'd0,
        CFG_BIND_MIN_Y     = 3'd1,
        CFG_BIND_MIN_Z     = 3'd2,
        CFG_BIND_MAX_X     = 3'd3,
        CFG_BIND_MAX_Y     = 3'd4,
        CFG_BIND_MAX_Z     = 3'd5,
        CFG_BIND_BOX_VALID = 3'd6
    } cfg_idx_t;

    // Bind box corners, index 0 is x.
    typedef struct packed {
        q16_t [NUM_AXES-1:0] lo;
        q16_t [NUM_AXES-1:0] hi;
    } bind_t;

    // Control part of a word travelling from front to back.
    typedef struct packed {
        logic       valid;
        logic       row_ok;
        logic [1:0] axis;
        logic       end_mark;
    } ctl_t;

    // A classified word with its products against both bind limits.
    typedef struct packed {
        ctl_t                 ctl;
        q16_t                 t;
        prod_t [NUM_AXES-1:0] p_lo;
        prod_t [NUM_AXES-1:0] p_hi;
    } item_t;

    // Full 32 x 32 signed product.
    function automatic prod_t mul_q16(input q16_t a, input q16_t b);
        prod_t p;
        p = a * b;
        return p;
    endfunction

    // Sum of three signed products without overflow.
    function automatic sum_t sum3(input prod_t a, input prod_t b, input prod_t c);
        sum_t s;
        s = sum_t'(a) + sum_t'(b) + sum_t'(c);
        return s;
    endfunction

    // Floor of the sum by 2^16, plus translation, saturated to 32 bits.
    function automatic q16_t sat_q16(input sum_t s, input q16_t t);
        logic signed [49:0] r;
        q16_t               v;
        r = 50'(s >>> 16) + 50'(t);
        if ((&r[49:31]) || !(|r[49:31]))
        begin
            v = r[31:0];
        end
        else if (r[49])
        begin
            v = SAT_MIN;
        end
        else
        begin
            v = SAT_MAX;
        end
        return v;
    endfunction

endpackage

>>> hdl/spb_ifs.sv
// ----------------------------------------------------------------------------
// Skinned palette bounds channel interfaces
// Row input, box result and configuration write channels.
// ----------------------------------------------------------------------------

// One matrix row, or an end mark, per word.
interface spb_row_if;
    logic               valid;
    logic               ready;
    logic               row_present;
    logic [1:0]         axis;
    logic signed [31:0] coef_x;
    logic signed [31:0] coef_y;
    logic signed [31:0] coef_z;
    logic signed [31:0] translation;
    logic               end_of_palette;

    modport source (output valid, row_present, axis, coef_x, coef_y, coef_z,
                    translation, end_of_palette, input ready);
    modport sink   (input valid, row_present, axis, coef_x, coef_y, coef_z,
                    translation, end_of_palette, output ready);
endinterface

// One enclosing box per word.
interface spb_box_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic               found;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    found, input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    found, output ready);
endinterface

// Register writes.
interface spb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/spb_front.sv
// ----------------------------------------------------------------------------
// Skinned palette bounds front end
// Accepts row words, classifies them and forms the six limit products.
// ----------------------------------------------------------------------------
module spb_front
    import spb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    spb_row_if.sink    rows,
    input  bind_t      bind_box,
    input  logic       q_full,
    output logic       q_push,
    output item_t      q_item
);

    ctl_t                 ctl_reg;
    ctl_t                 ctl_next;
    q16_t                 t_reg;
    prod_t [NUM_AXES-1:0] p_lo_reg;
    prod_t [NUM_AXES-1:0] p_hi_reg;
    q16_t  [NUM_AXES-1:0] coef;
    logic                 accept;
    logic                 row_ok;

    assign coef[0] = rows.coef_x;
    assign coef[1] = rows.coef_y;
    assign coef[2] = rows.coef_z;

    // The stage frees up whenever its word moves into the queue.
    assign rows.ready = !ctl_reg.valid || !q_full;
    assign accept     = rows.valid && rows.ready;
    assign q_push     = ctl_reg.valid && !q_full;

    // A row on the unused axis code is dropped; a word with nothing to do is not queued.
    assign row_ok = rows.row_present && (axis_t'(rows.axis) != AXIS_NONE);

    // Stage control.
    always_comb
    begin
        ctl_next = ctl_reg;
        if (accept)
        begin
            ctl_next.valid    = row_ok || rows.end_of_palette;
            ctl_next.row_ok   = row_ok;
            ctl_next.axis     = rows.axis;
            ctl_next.end_mark = rows.end_of_palette;
        end
        else if (q_push)
        begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    // Products of each coefficient with the lower and upper bind limit.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg <= rows.translation;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                p_lo_reg[i] <= mul_q16(coef[i], bind_box.lo[i]);
                p_hi_reg[i] <= mul_q16(coef[i], bind_box.hi[i]);
            end
        end
    end

    assign q_item.ctl  = ctl_reg;
    assign q_item.t    = t_reg;
    assign q_item.p_lo = p_lo_reg;
    assign q_item.p_hi = p_hi_reg;

endmodule

>>> hdl/spb_queue.sv
// ----------------------------------------------------------------------------
// Skinned palette bounds queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module spb_queue
    import spb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_item,
    input  logic  pop,
    output item_t rd_item,
    output logic  full,
    output logic  empty
);

`include "skinned_palette_bounds_core_macros.svh"

    item_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = mem[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                count_reg <= QCNT_W'(count_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                count_reg <= QCNT_W'(count_reg - 1'b1);
            end
        end
    end

    `SPB_ASSERT_NOW(a_no_push_full, push, !full, "queue written while full")
    `SPB_ASSERT_NOW(a_no_pop_empty, pop, !empty, "queue read while empty")

endmodule

>>> hdl/spb_back.sv
// ----------------------------------------------------------------------------
// Skinned palette bounds back end
// Folds each row into the running box and delivers the box on an end mark.
// ----------------------------------------------------------------------------
module spb_back
    import spb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      q_item,
    input  logic       q_empty,
    output logic       q_pop,
    input  logic       bind_valid,
    spb_box_if.source  box
);

`include "skinned_palette_bounds_core_macros.svh"

    logic                 enable;

    // Pipeline stages.
    ctl_t                 b1_ctl_reg;
    ctl_t                 b2_ctl_reg;
    ctl_t                 b3_ctl_reg;
    q16_t                 b1_t_reg;
    q16_t                 b2_t_reg;
    prod_t [NUM_AXES-1:0] b1_lo_reg;
    prod_t [NUM_AXES-1:0] b1_hi_reg;
    sum_t                 b2_lo_reg;
    sum_t                 b2_hi_reg;
    q16_t                 b3_lo_reg;
    q16_t                 b3_hi_reg;

    // Accumulators.
    q16_t [NUM_AXES-1:0]  acc_min_reg;
    q16_t [NUM_AXES-1:0]  acc_max_reg;
    logic                 any_reg;
    q16_t [NUM_AXES-1:0]  acc_min_next;
    q16_t [NUM_AXES-1:0]  acc_max_next;
    logic                 any_next;
    q16_t [NUM_AXES-1:0]  fold_min;
    q16_t [NUM_AXES-1:0]  fold_max;
    logic                 fold_any;
    logic                 last_end;

    // Output register.
    logic                 box_valid_reg;
    logic                 box_valid_next;
    q16_t [NUM_AXES-1:0]  box_min_reg;
    q16_t [NUM_AXES-1:0]  box_max_reg;
    logic                 found_reg;

    // The whole back end moves together unless a finished box is stuck.
    assign enable   = !box_valid_reg || box.ready;
    assign q_pop    = enable && !q_empty;
    assign last_end = enable && b3_ctl_reg.valid && b3_ctl_reg.end_mark;

    // Stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_ctl_reg <= '0;
            b2_ctl_reg <= '0;
            b3_ctl_reg <= '0;
        end
        else if (enable)
        begin
            b1_ctl_reg <= q_pop ? q_item.ctl : '0;
            b2_ctl_reg <= b1_ctl_reg;
            b3_ctl_reg <= b2_ctl_reg;
        end
    end

    // Pick the smaller and larger product per term, sum the terms, then
    // scale, translate and saturate. Scaling is monotonic, so the extremes
    // of the sums give the extremes over all eight corners.
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            b1_t_reg <= q_item.t;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (q_item.p_lo[i] < q_item.p_hi[i])
                begin
                    b1_lo_reg[i] <= q_item.p_lo[i];
                    b1_hi_reg[i] <= q_item.p_hi[i];
                end
                else
                begin
                    b1_lo_reg[i] <= q_item.p_hi[i];
                    b1_hi_reg[i] <= q_item.p_lo[i];
                end
            end
            b2_t_reg  <= b1_t_reg;
            b2_lo_reg <= sum3(b1_lo_reg[0], b1_lo_reg[1], b1_lo_reg[2]);
            b2_hi_reg <= sum3(b1_hi_reg[0], b1_hi_reg[1], b1_hi_reg[2]);
            b3_lo_reg <= sat_q16(b2_lo_reg, b2_t_reg);
            b3_hi_reg <= sat_q16(b2_hi_reg, b2_t_reg);
        end
    end

    // Fold the row into its axis, then close the palette on an end mark.
    always_comb
    begin
        fold_min = acc_min_reg;
        fold_max = acc_max_reg;
        fold_any = any_reg;
        if (b3_ctl_reg.valid && b3_ctl_reg.row_ok)
        begin
            fold_any = 1'b1;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (b3_ctl_reg.axis == 2'(i))
                begin
                    if (b3_lo_reg < acc_min_reg[i])
                    begin
                        fold_min[i] = b3_lo_reg;
                    end
                    if (b3_hi_reg > acc_max_reg[i])
                    begin
                        fold_max[i] = b3_hi_reg;
                    end
                end
            end
        end

        acc_min_next = acc_min_reg;
        acc_max_next = acc_max_reg;
        any_next     = any_reg;
        if (enable && b3_ctl_reg.valid)
        begin
            if (b3_ctl_reg.end_mark)
            begin
                acc_min_next = {NUM_AXES{SAT_MAX}};
                acc_max_next = {NUM_AXES{SAT_MIN}};
                any_next     = 1'b0;
            end
            else
            begin
                acc_min_next = fold_min;
                acc_max_next = fold_max;
                any_next     = fold_any;
            end
        end

        box_valid_next = box_valid_reg && !box.ready;
        if (last_end)
        begin
            box_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_min_reg   <= {NUM_AXES{SAT_MAX}};
            acc_max_reg   <= {NUM_AXES{SAT_MIN}};
            any_reg       <= 1'b0;
            box_valid_reg <= 1'b0;
        end
        else
        begin
            acc_min_reg   <= acc_min_next;
            acc_max_reg   <= acc_max_next;
            any_reg       <= any_next;
            box_valid_reg <= box_valid_next;
        end
    end

    // Result word; an empty palette or a missing bind box reads as zero.
    always_ff @(posedge clk)
    begin
        if (last_end)
        begin
            found_reg <= bind_valid && fold_any;
            if (bind_valid && fold_any)
            begin
                box_min_reg <= fold_min;
                box_max_reg <= fold_max;
            end
            else
            begin
                box_min_reg <= '0;
                box_max_reg <= '0;
            end
        end
    end

    assign box.valid = box_valid_reg;
    assign box.min_x = box_min_reg[0];
    assign box.min_y = box_min_reg[1];
    assign box.min_z = box_min_reg[2];
    assign box.max_x = box_max_reg[0];
    assign box.max_y = box_max_reg[1];
    assign box.max_z = box_max_reg[2];
    assign box.found = found_reg;

    `SPB_ASSERT_NOW(a_empty_box_zero, box_valid_reg && !found_reg,
        (box_min_reg == '0) && (box_max_reg == '0), "empty box not zero")
    `SPB_ASSERT_NEXT(a_clear_after_end, last_end,
        !any_reg && (acc_min_reg[0] == SAT_MAX) && (acc_max_reg[0] == SAT_MIN),
        "accumulators not cleared after end mark")
    `SPB_ASSERT_NEXT(a_stall_holds, !enable, $stable(b3_ctl_reg),
        "last stage moved while the box was stalled")

endmodule

>>> hdl/skinned_palette_bounds_core.sv
// ----------------------------------------------------------------------------
// Skinned palette bounds core
// Enclosing axis-aligned box of a bind box under a palette of bone matrices.
// ----------------------------------------------------------------------------
// Each row word carries one affine row of one matrix, tagged with its axis.
// The core takes one row word per cycle while the queue has room and folds
// the eight corner products of that row into the running minimum and maximum
// of its axis. A word with the end mark gives one box word on the box channel.
// The taking edge registers the six 32 x 32 products in the front end. The
// word is then written into the four-entry queue, passes the select, sum and
// saturate registers of the back end, and is folded into the accumulators as
// the box is registered. The sustained rate of one word per cycle while
// nothing stalls is set by the front-end multipliers and the fold into the
// accumulators. Row words keep flowing into the queue while a finished box
// waits to be taken, until the queue is full.
// Configuration writes are always ready and must only happen while the core
// is idle.
// ----------------------------------------------------------------------------
module skinned_palette_bounds_core
    import spb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    spb_cfg_if.sink    cfg,
    spb_row_if.sink    rows,
    spb_box_if.source  box
);

    bind_t  bind_reg;
    logic   bind_valid_reg;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    item_t  q_wr_item;
    item_t  q_rd_item;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bind_reg       <= '0;
            bind_valid_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_BIND_MIN_X:     bind_reg.lo[0] <= cfg.data;
                CFG_BIND_MIN_Y:     bind_reg.lo[1] <= cfg.data;
                CFG_BIND_MIN_Z:     bind_reg.lo[2] <= cfg.data;
                CFG_BIND_MAX_X:     bind_reg.hi[0] <= cfg.data;
                CFG_BIND_MAX_Y:     bind_reg.hi[1] <= cfg.data;
                CFG_BIND_MAX_Z:     bind_reg.hi[2] <= cfg.data;
                CFG_BIND_BOX_VALID: bind_valid_reg <= cfg.data[0];
                default:            ;
            endcase
        end
    end

    // Front end: accept and classify rows, form the limit products.
    spb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rows     (rows),
        .bind_box (bind_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_wr_item)
    );

    // Decoupling queue.
    spb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_wr_item),
        .pop     (q_pop),
        .rd_item (q_rd_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back end: reduce, accumulate and deliver the box.
    spb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_item     (q_rd_item),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .bind_valid (bind_valid_reg),
        .box        (box)
    );

endmodule

>>> sim/skinned_palette_bounds_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Skinned palette bounds core testbench
// Streams matrix rows and end marks into the core, predicts each enclosing
// box in the bench and compares every box word taken from the core, field by
// field. A short directed plan comes first, then randomised palettes under
// several bind box settings, with bursty row traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module skinned_palette_bounds_core_test
    import spb_pkg::*;
();

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 120;
    localparam int RANDOM_WORDS  = 950;
    localparam int PHASE_WORDS   = 120;

    // Handy Q16.16 values for the directed plan.
    localparam q16_t Q_ZERO  = 32'sh0000_0000;
    localparam q16_t Q_HALF  = 32'sh0000_8000;
    localparam q16_t Q_ONE   = 32'sh0001_0000;
    localparam q16_t Q_TWO   = 32'sh0002_0000;
    localparam q16_t Q_THREE = 32'sh0003_0000;

    // One row word as driven onto the row channel.
    typedef struct packed {
        logic  row_present;
        axis_t axis;
        q16_t  coef_x;
        q16_t  coef_y;
        q16_t  coef_z;
        q16_t  translation;
        logic  end_of_palette;
    } row_word_t;

    // One box word as seen on the box channel.
    typedef struct packed {
        q16_t min_x;
        q16_t min_y;
        q16_t min_z;
        q16_t max_x;
        q16_t max_y;
        q16_t max_z;
        logic found;
    } box_word_t;

    // One step of the directed plan: a register write or a row word.
    typedef struct packed {
        logic        is_cfg;
        cfg_idx_t    reg_idx;
        logic [31:0] reg_value;
        row_word_t   word;
        logic        typed;
        box_word_t   want;
    } plan_step_t;

    logic clk = 1'b0;
    logic rst_n;

    spb_cfg_if cfg_ch ();
    spb_row_if rows_ch ();
    spb_box_if box_ch ();

    skinned_palette_bounds_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .rows  (rows_ch),
        .box   (box_ch)
    );

    // Bench copy of the bind box and of the running limits.
    q16_t bind_lo [NUM_AXES];
    q16_t bind_hi [NUM_AXES];
    logic bind_ok;
    q16_t run_lo [NUM_AXES];
    q16_t run_hi [NUM_AXES];
    logic rows_seen;

    box_word_t pending_boxes [$];
    logic      failed = 1'b0;
    int        live_words = 0;
    int        burst_left = 0;
    int        hold_requests = 0;
    int        hold_served = 0;

    // Clock generation.
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Give up after a generous fixed time.
    initial
    begin
        #4_000_000;
        $display("FAIL skinned_palette_bounds_core");
        $finish;
    end

    // Dot product of one row with one corner, floored by 2^16 and saturated.
    function automatic q16_t corner_dot(input q16_t cx, cy, cz, tr, x, y, z);
        logic signed [65:0] dot;
        logic signed [65:0] r;
        dot = cx * x + cy * y + cz * z;
        r = (dot >>> 16) + tr;
        if (r > 66'sd2147483647)
        begin
            return SAT_MAX;
        end
        if (r < -66'sd2147483648)
        begin
            return SAT_MIN;
        end
        return r[31:0];
    endfunction

    // Running limits back to their empty values.
    function automatic void clear_runs();
        for (int a = 0; a < NUM_AXES; a++)
        begin
            run_lo[a] = SAT_MAX;
            run_hi[a] = SAT_MIN;
        end
        rows_seen = 1'b0;
    endfunction

    // Mirror of a register write.
    function automatic void set_bind_reg(input cfg_idx_t idx, input logic [31:0] value);
        case (idx)
            CFG_BIND_MIN_X:     bind_lo[0] = value;
            CFG_BIND_MIN_Y:     bind_lo[1] = value;
            CFG_BIND_MIN_Z:     bind_lo[2] = value;
            CFG_BIND_MAX_X:     bind_hi[0] = value;
            CFG_BIND_MAX_Y:     bind_hi[1] = value;
            CFG_BIND_MAX_Z:     bind_hi[2] = value;
            CFG_BIND_BOX_VALID: bind_ok = value[0];
            default:            ;
        endcase
    endfunction

    // Folds one accepted word into the limits; returns 1 when a box is due.
    function automatic logic bounds_after_word(input row_word_t w, output box_word_t res);
        int   a;
        q16_t v;
        res = '0;
        if (w.row_present && w.axis != AXIS_NONE)
        begin
            a = int'(w.axis);
            for (int k = 0; k < 8; k++)
            begin
                v = corner_dot(w.coef_x, w.coef_y, w.coef_z, w.translation,
                               k[0] ? bind_hi[0] : bind_lo[0],
                               k[1] ? bind_hi[1] : bind_lo[1],
                               k[2] ? bind_hi[2] : bind_lo[2]);
                if (v < run_lo[a])
                begin
                    run_lo[a] = v;
                end
                if (v > run_hi[a])
                begin
                    run_hi[a] = v;
                end
            end
            rows_seen = 1'b1;
        end
        if (!w.end_of_palette)
        begin
            return 1'b0;
        end
        if (bind_ok && rows_seen)
        begin
            res.min_x = run_lo[0];
            res.min_y = run_lo[1];
            res.min_z = run_lo[2];
            res.max_x = run_hi[0];
            res.max_y = run_hi[1];
            res.max_z = run_hi[2];
            res.found = 1'b1;
        end
        clear_runs();
        return 1'b1;
    endfunction

    function automatic row_word_t row_word(input logic rp, input axis_t ax,
                                           input q16_t cx, cy, cz, tr, input logic eop);
        row_word_t w;
        w.row_present    = rp;
        w.axis           = ax;
        w.coef_x         = cx;
        w.coef_y         = cy;
        w.coef_z         = cz;
        w.translation    = tr;
        w.end_of_palette = eop;
        return w;
    endfunction

    function automatic box_word_t box_of(input q16_t lx, ly, lz, hx, hy, hz, input logic f);
        box_word_t b;
        b.min_x = lx;
        b.min_y = ly;
        b.min_z = lz;
        b.max_x = hx;
        b.max_y = hy;
        b.max_z = hz;
        b.found = f;
        return b;
    endfunction

    function automatic plan_step_t cfg_step(input cfg_idx_t idx, input logic [31:0] value);
        plan_step_t s;
        s = '0;
        s.is_cfg    = 1'b1;
        s.reg_idx   = idx;
        s.reg_value = value;
        return s;
    endfunction

    function automatic plan_step_t word_step(input row_word_t w, input logic typed,
                                             input box_word_t want);
        plan_step_t s;
        s = '0;
        s.word  = w;
        s.typed = typed;
        s.want  = want;
        return s;
    endfunction

    // Word with every field drawn at random.
    function automatic row_word_t random_word(input logic eop);
        return row_word(1'($urandom_range(0, 1)), axis_t'($urandom_range(0, 3)),
                        $urandom, $urandom, $urandom, $urandom, eop);
    endfunction

    // Mostly small matrix entries, with extremes and raw bit patterns mixed in.
    function automatic q16_t random_coef();
        case ($urandom_range(0, 15))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return Q_ZERO;
            3, 4:    return $urandom;
            default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
        endcase
    endfunction

    function automatic q16_t random_shift();
        case ($urandom_range(0, 15))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h200_0000) - 32'h100_0000;
        endcase
    endfunction

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(0, 3))
            0:       return SAT_MIN;
            1:       return SAT_MAX;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // Lets the core empty itself before a register write or the end.
    task automatic drain_core();
        rows_ch.valid <= 1'b0;
        while (pending_boxes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write, made only while the core is idle.
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        drain_core();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(negedge clk); while (!cfg_ch.ready);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        set_bind_reg(idx, value);
        @(posedge clk);
    endtask

    // Offers one row word in bursts with random gaps, and books its box.
    task automatic send_word(input row_word_t w, input logic typed, input box_word_t want);
        int        gap;
        box_word_t predicted;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                rows_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rows_ch.valid          <= 1'b1;
        rows_ch.row_present    <= w.row_present;
        rows_ch.axis           <= w.axis;
        rows_ch.coef_x         <= w.coef_x;
        rows_ch.coef_y         <= w.coef_y;
        rows_ch.coef_z         <= w.coef_z;
        rows_ch.translation    <= w.translation;
        rows_ch.end_of_palette <= w.end_of_palette;
        do @(negedge clk); while (!rows_ch.ready);
        @(posedge clk);
        if (bounds_after_word(w, predicted))
        begin
            pending_boxes.push_back(typed ? want : predicted);
        end
        if (w.end_of_palette || (w.row_present && w.axis != AXIS_NONE))
        begin
            live_words++;
        end
    endtask

    // Writes a fresh bind box of the given style and its valid flag.
    task automatic load_random_bind(input int style);
        logic [31:0] v [6];
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] flag;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            case (style)
                0:
                begin
                    lo = 32'h0 - $urandom_range(0, 100 << 16);
                    hi = $urandom_range(0, 100 << 16);
                    if ($urandom_range(0, 7) == 0)
                    begin
                        {lo, hi} = {hi, lo};
                    end
                end
                1:
                begin
                    lo = $urandom;
                    hi = $urandom;
                end
                2:
                begin
                    lo = extreme_value();
                    hi = extreme_value();
                end
                default:
                begin
                    lo = $urandom_range(0, 32'h40_0000) - 32'h20_0000;
                    hi = lo;
                end
            endcase
            v[a]     = lo;
            v[a + 3] = hi;
        end
        for (int i = 0; i < 6; i++)
        begin
            write_reg(cfg_idx_t'(i), v[i]);
        end
        flag    = $urandom;
        flag[0] = ($urandom_range(0, 7) != 0);
        write_reg(CFG_BIND_BOX_VALID, flag);
    endtask

    // One palette: mostly whole matrices, sometimes broken or noisy streams.
    task automatic send_palette();
        int        kind;
        int        mats;
        int        n;
        logic      join_end;
        logic      last;
        row_word_t w;
        kind     = $urandom_range(0, 9);
        join_end = 1'($urandom_range(0, 1));
        if (kind <= 6)
        begin
            mats = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            for (int m = 0; m < mats; m++)
            begin
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    last = (m == mats - 1) && (a == NUM_AXES - 1);
                    // Now and then an axis is left out of a matrix.
                    if (!last && $urandom_range(0, 19) == 0)
                    begin
                        continue;
                    end
                    w = row_word(1'b1, axis_t'(a), random_coef(), random_coef(),
                                 random_coef(), random_shift(), last && join_end);
                    send_word(w, 1'b0, '0);
                end
            end
            if (!join_end)
            begin
                w = random_word(1'b1);
                w.row_present = 1'b0;
                send_word(w, 1'b0, '0);
            end
        end
        else if (kind == 7)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_word(random_word(1'b0), 1'b0, '0);
            send_word(random_word(1'b1), 1'b0, '0);
        end
        else if (kind == 8)
        begin
            // Words that carry nothing, then a bare end mark.
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                w = random_word(1'b0);
                if ($urandom_range(0, 1) == 0)
                begin
                    w.row_present = 1'b0;
                end
                else
                begin
                    w.axis = AXIS_NONE;
                end
                send_word(w, 1'b0, '0);
            end
            w = random_word(1'b1);
            w.row_present = 1'b0;
            send_word(w, 1'b0, '0);
        end
        else
        begin
            send_word(random_word(1'b1), 1'b0, '0);
        end
    endtask

    // Receiver: own stall pattern, plus a long hold when one is requested.
    initial
    begin : receiver
        int hold_left;
        int mode_left;
        int rx_mode;
        int rx_tick;
        hold_left    = 0;
        mode_left    = 0;
        rx_mode      = 0;
        rx_tick      = 0;
        box_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                box_ch.ready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = LONG_HOLD - 1;
                box_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                rx_tick++;
                case (rx_mode)
                    0:       box_ch.ready <= 1'b1;
                    1:       box_ch.ready <= 1'($urandom_range(0, 1));
                    2:       box_ch.ready <= (rx_tick % 4) != 0;
                    default: box_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Box monitor: sampled mid-cycle, so the word is taken at the next edge.
    always @(negedge clk)
    begin
        if (rst_n && box_ch.valid && box_ch.ready)
        begin
            if (pending_boxes.size() == 0)
            begin
                $error("box word arrived with no box expected");
                failed = 1'b1;
            end
            else
            begin
                check_field("min_x", pending_boxes[0].min_x, box_ch.min_x);
                check_field("min_y", pending_boxes[0].min_y, box_ch.min_y);
                check_field("min_z", pending_boxes[0].min_z, box_ch.min_z);
                check_field("max_x", pending_boxes[0].max_x, box_ch.max_x);
                check_field("max_y", pending_boxes[0].max_y, box_ch.max_y);
                check_field("max_z", pending_boxes[0].max_z, box_ch.max_z);
                check_field("found", 32'(pending_boxes[0].found), 32'(box_ch.found));
                void'(pending_boxes.pop_front());
            end
        end
    end

    // Main stimulus.
    initial
    begin : stimulus
        plan_step_t plan [$];
        box_word_t  empty_box;
        int         random_goal;
        int         phase_goal;
        int         phase;

        rst_n                  = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = CFG_BIND_MIN_X;
        cfg_ch.data            = '0;
        rows_ch.valid          = 1'b0;
        rows_ch.row_present    = 1'b0;
        rows_ch.axis           = AXIS_X;
        rows_ch.coef_x         = '0;
        rows_ch.coef_y         = '0;
        rows_ch.coef_z         = '0;
        rows_ch.translation    = '0;
        rows_ch.end_of_palette = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            bind_lo[a] = Q_ZERO;
            bind_hi[a] = Q_ZERO;
        end
        bind_ok = 1'b0;
        clear_runs();
        empty_box = box_of(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0);

        // Empty palette and a row with no bind box, both straight after reset.
        plan.push_back(word_step(row_word(1'b0, AXIS_X, Q_ZERO, Q_ZERO, Q_ZERO,
                                          Q_ZERO, 1'b1), 1'b1, empty_box));
        plan.push_back(word_step(row_word(1'b1, AXIS_X, Q_ONE, Q_TWO, Q_THREE,
                                          Q_HALF, 1'b1), 1'b1, empty_box));
        // A plain box of +-1, +-2, +-3 along x, y and z.
        plan.push_back(cfg_step(CFG_BIND_MIN_X, -Q_ONE));
        plan.push_back(cfg_step(CFG_BIND_MIN_Y, -Q_TWO));
        plan.push_back(cfg_step(CFG_BIND_MIN_Z, -Q_THREE));
        plan.push_back(cfg_step(CFG_BIND_MAX_X, Q_ONE));
        plan.push_back(cfg_step(CFG_BIND_MAX_Y, Q_TWO));
        plan.push_back(cfg_step(CFG_BIND_MAX_Z, Q_THREE));
        plan.push_back(cfg_step(CFG_BIND_BOX_VALID, 32'h0000_0001));
        // Bind box present but no row seen.
        plan.push_back(word_step(row_word(1'b0, AXIS_Z, Q_ZERO, Q_ZERO, Q_ZERO,
                                          Q_ZERO, 1'b1), 1'b1, empty_box));
        // Identity-like rows; the ignored axis code and an idle word in between;
        // the last row and the end mark share one word.
        plan.push_back(word_step(row_word(1'b1, AXIS_X, Q_ONE, Q_ZERO, Q_ZERO,
                                          Q_ZERO, 1'b0), 1'b0, '0));
        plan.push_back(word_step(row_word(1'b1, AXIS_Y, Q_ZERO, Q_ONE, Q_ZERO,
                                          Q_HALF, 1'b0), 1'b0, '0));
        plan.push_back(word_step(row_word(1'b1, AXIS_NONE, SAT_MAX, SAT_MAX, SAT_MAX,
                                          SAT_MIN, 1'b0), 1'b0, '0));
        plan.push_back(word_step(row_word(1'b0, AXIS_X, SAT_MIN, SAT_MIN, SAT_MIN,
                                          SAT_MAX, 1'b0), 1'b0, '0));
        plan.push_back(word_step(row_word(1'b1, AXIS_Z, Q_ZERO, Q_ZERO, Q_TWO,
                                          Q_ZERO, 1'b1), 1'b1,
                                 box_of(-Q_ONE, 32'shFFFE_8000, 32'shFFFA_0000,
                                        Q_ONE, 32'sh0002_8000, 32'sh0006_0000, 1'b1)));
        // Only x rowed: y and z keep their empty limits.
        plan.push_back(word_step(row_word(1'b1, AXIS_X, Q_ONE, Q_ZERO, Q_ZERO,
                                          Q_ZERO, 1'b1), 1'b1,
                                 box_of(-Q_ONE, SAT_MAX, SAT_MAX,
                                        Q_ONE, SAT_MIN, SAT_MIN, 1'b1)));
        // A row on the ignored axis code does not count as a row seen.
        plan.push_back(word_step(row_word(1'b1, AXIS_NONE, Q_ONE, Q_ONE, Q_ONE,
                                          Q_ONE, 1'b1), 1'b1, empty_box));
        // Valid flag cleared through bit zero only, then set again.
        plan.push_back(cfg_step(CFG_BIND_BOX_VALID, 32'hFFFF_FFFE));
        plan.push_back(word_step(row_word(1'b1, AXIS_Y, Q_ONE, Q_ONE, Q_ONE,
                                          Q_ONE, 1'b1), 1'b1, empty_box));
        plan.push_back(cfg_step(CFG_BIND_BOX_VALID, 32'h8000_0001));
        // Widest bind box and extreme rows: the dot products saturate.
        plan.push_back(cfg_step(CFG_BIND_MIN_X, SAT_MIN));
        plan.push_back(cfg_step(CFG_BIND_MIN_Y, SAT_MIN));
        plan.push_back(cfg_step(CFG_BIND_MIN_Z, SAT_MIN));
        plan.push_back(cfg_step(CFG_BIND_MAX_X, SAT_MAX));
        plan.push_back(cfg_step(CFG_BIND_MAX_Y, SAT_MAX));
        plan.push_back(cfg_step(CFG_BIND_MAX_Z, SAT_MAX));
        plan.push_back(word_step(row_word(1'b1, AXIS_X, SAT_MAX, SAT_MAX, SAT_MAX,
                                          SAT_MAX, 1'b0), 1'b0, '0));
        plan.push_back(word_step(row_word(1'b1, AXIS_Y, SAT_MIN, SAT_MIN, SAT_MIN,
                                          SAT_MIN, 1'b0), 1'b0, '0));
        // Register changed part way through a palette.
        plan.push_back(cfg_step(CFG_BIND_MIN_Z, Q_ZERO));
        plan.push_back(word_step(row_word(1'b1, AXIS_Z, SAT_MAX, SAT_MIN, 32'shFFFF_FFFF,
                                          SAT_MIN, 1'b1), 1'b0, '0));
        // Bind box with its lower limits above the upper ones.
        plan.push_back(cfg_step(CFG_BIND_MIN_X, Q_TWO));
        plan.push_back(cfg_step(CFG_BIND_MIN_Y, Q_TWO));
        plan.push_back(cfg_step(CFG_BIND_MIN_Z, Q_TWO));
        plan.push_back(cfg_step(CFG_BIND_MAX_X, -Q_TWO));
        plan.push_back(cfg_step(CFG_BIND_MAX_Y, -Q_TWO));
        plan.push_back(cfg_step(CFG_BIND_MAX_Z, -Q_TWO));
        plan.push_back(word_step(row_word(1'b1, AXIS_X, Q_ONE, Q_HALF, -Q_ONE,
                                          SAT_MAX, 1'b0), 1'b0, '0));
        plan.push_back(word_step(row_word(1'b1, AXIS_Y, -Q_HALF, Q_THREE, Q_ONE,
                                          SAT_MIN, 1'b0), 1'b0, '0));
        plan.push_back(word_step(row_word(1'b1, AXIS_Z, Q_ZERO, Q_ZERO, Q_ZERO,
                                          -Q_HALF, 1'b1), 1'b0, '0));

        // Reset is released on a rising edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                write_reg(plan[i].reg_idx, plan[i].reg_value);
            end
            else
            begin
                send_word(plan[i].word, plan[i].typed, plan[i].want);
            end
        end

        // Random palettes, one bind box setting per phase.
        random_goal = live_words + RANDOM_WORDS;
        for (phase = 0; live_words < random_goal; phase++)
        begin
            load_random_bind((phase < 4) ? phase : $urandom_range(0, 3));
            // Hold the receiver off once so that the core backs up.
            if (phase == 1)
            begin
                hold_requests++;
            end
            phase_goal = live_words + PHASE_WORDS;
            while (live_words < phase_goal && live_words < random_goal)
            begin
                send_palette();
            end
        end

        drain_core();
        if (!failed)
        begin
            $display("PASS skinned_palette_bounds_core");
        end
        else
        begin
            $display("FAIL skinned_palette_bounds_core");
        end
        $finish;
    end

endmodule
